// ----- hdl/oid_pkg.sv -----
`timescale 1ns / 1ps

package oid_pkg;

  localparam int unsigned MaxIdentifiersDefault = 128;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned PosWidth = 7;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned LenWidth = 16;
  localparam logic [7:0] FirstArcDivisor = 8'd40;
  localparam logic [7:0] GroupMask = 8'h7f;
  localparam logic [7:0] MoreMask = 8'h80;

  typedef struct packed {
    logic                  identifier_valid;
    logic [ValueWidth-1:0] identifier_value;
    logic [PosWidth-1:0]   identifier_position;
    logic                  end_of_object;
    logic                  too_long;
    logic [CountWidth-1:0] identifier_count;
  } result_t;

  typedef struct packed {
    logic [7:0]          content_byte;
    logic [LenWidth-1:0] content_length;
    logic                first_byte;
    logic                final_byte;
  } item_t;

  // byte / 40 via reciprocal: (b * 205) >> 13 is exact for any 8-bit b
  function automatic logic [7:0] div40(input logic [7:0] b);
    logic [15:0] prod;
    prod = 16'(b) * 16'd205;
    return 8'(prod >> 13);
  endfunction

  function automatic logic [7:0] mod40(input logic [7:0] b);
    logic [7:0] q;
    q = div40(b);
    return 8'(b - 8'(q * FirstArcDivisor));
  endfunction

endpackage

// ----- hdl/oid_in_if.sv -----
`timescale 1ns / 1ps

interface oid_in_if;
  import oid_pkg::*;
  logic                valid;
  logic                ready;
  logic [7:0]          content_byte;
  logic [LenWidth-1:0] content_length;
  logic                first_byte;
  logic                final_byte;

  modport source (output valid, content_byte, content_length, first_byte, final_byte,
                  input ready);
  modport sink (input valid, content_byte, content_length, first_byte, final_byte,
                output ready);
endinterface

// ----- hdl/oid_out_if.sv -----
`timescale 1ns / 1ps

interface oid_out_if;
  import oid_pkg::*;
  logic                  valid;
  logic                  ready;
  logic                  identifier_valid;
  logic [ValueWidth-1:0] identifier_value;
  logic [PosWidth-1:0]   identifier_position;
  logic                  end_of_object;
  logic                  too_long;
  logic [CountWidth-1:0] identifier_count;

  modport source (output valid, identifier_valid, identifier_value, identifier_position,
                  end_of_object, too_long, identifier_count, input ready);
  modport sink (input valid, identifier_valid, identifier_value, identifier_position,
                end_of_object, too_long, identifier_count, output ready);
endinterface

// ----- hdl/oid_step.sv -----
`timescale 1ns / 1ps

module oid_step
  import oid_pkg::*;
#(
  parameter int unsigned MAX_IDENTIFIERS = MaxIdentifiersDefault
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  item_t      item,
  output result_t    res0,
  output result_t    res1,
  output logic [1:0] res_num
);

  localparam logic [CountWidth-1:0] MaxCount = CountWidth'(MAX_IDENTIFIERS);
  localparam logic [LenWidth-1:0] MaxLen = LenWidth'(MAX_IDENTIFIERS - 1);

  logic [ValueWidth-1:0] accumulator, accumulator_next;
  logic [CountWidth-1:0] decoded_count, decoded_count_next;
  logic                  discarding, discarding_next;

  logic [ValueWidth-1:0] shifted;
  logic                  term, emit;
  logic [7:0]            first_q, first_r;

  always_comb begin
    shifted = {accumulator[ValueWidth-8:0], item.content_byte[6:0] & GroupMask[6:0]};
    term = (item.content_byte & MoreMask) == 8'h00;
    emit = term && (decoded_count < MaxCount);
    first_q = div40(item.content_byte);
    first_r = mod40(item.content_byte);

    accumulator_next = accumulator;
    decoded_count_next = decoded_count;
    discarding_next = discarding;
    res0 = '0;
    res1 = '0;
    res_num = 2'd0;

    if (item.first_byte) begin
      accumulator_next = '0;
      if (item.content_length > MaxLen) begin
        discarding_next = 1'b1;
        decoded_count_next = '0;
        res0.end_of_object = 1'b1;
        res0.too_long = 1'b1;
        res_num = 2'd1;
      end else if (item.content_length == '0) begin
        discarding_next = 1'b1;
        decoded_count_next = CountWidth'(2);
        res0.identifier_valid = 1'b1;
        res1.identifier_valid = 1'b1;
        res1.identifier_position = PosWidth'(1);
        res1.end_of_object = 1'b1;
        res1.identifier_count = CountWidth'(2);
        res_num = 2'd2;
      end else begin
        discarding_next = item.final_byte;
        decoded_count_next = CountWidth'(2);
        res0.identifier_valid = 1'b1;
        res0.identifier_value = ValueWidth'(first_q);
        res1.identifier_valid = 1'b1;
        res1.identifier_value = ValueWidth'(first_r);
        res1.identifier_position = PosWidth'(1);
        res1.end_of_object = item.final_byte;
        res1.identifier_count = item.final_byte ? CountWidth'(2) : '0;
        res_num = 2'd2;
      end
    end else if (!discarding) begin
      accumulator_next = (term || item.final_byte) ? '0 : shifted;
      decoded_count_next = decoded_count + CountWidth'(emit);
      res0.identifier_valid = emit;
      res0.identifier_value = emit ? shifted : '0;
      res0.identifier_position = emit ? decoded_count[PosWidth-1:0] : '0;
      if (item.final_byte) begin
        discarding_next = 1'b1;
        res0.end_of_object = 1'b1;
        res0.identifier_count = decoded_count + CountWidth'(emit);
        res_num = 2'd1;
      end else if (emit) begin
        res_num = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accumulator <= '0;
      decoded_count <= '0;
      discarding <= 1'b0;
    end else if (accept) begin
      accumulator <= accumulator_next;
      decoded_count <= decoded_count_next;
      discarding <= discarding_next;
    end
  end

endmodule

// ----- hdl/object_identifier_decoder_core.sv -----
`timescale 1ns / 1ps
// BER object identifier decoder.
// ingress: one content byte of an identifier per word, with the declared
//   content length and first/final markers on every word.
// egress: one decoded sub-identifier, error or end result per word.
// Each accepted byte is decoded in the cycle it is taken; its results sit
// in a four-word output queue and are offered from the next cycle.
// Continuation bytes give at most one result each and run at one byte per
// cycle while ingress.ready is high. A first byte gives two results, so a
// stream of first bytes is limited by the single egress port.
// ingress.ready is high while the queue has room for two words, so input
// is taken whilst earlier results still wait; when the receiver stalls,
// bytes are taken until three or four words wait, then ingress is held
// off, also for bytes that give no result.
// Reset (rst, synchronous) empties the queue and clears the accumulator,
// the count and the discard flag.

module object_identifier_decoder_core
  import oid_pkg::*;
#(
  parameter int unsigned MAX_IDENTIFIERS = MaxIdentifiersDefault
) (
  input logic clk,
  input logic rst,
  oid_in_if.sink ingress,
  oid_out_if.source egress
);

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned PtrWidth = $clog2(QueueDepth);

  item_t      item;
  result_t    res0, res1;
  logic [1:0] res_num;
  logic       in_acc, out_acc;

  result_t               queue [QueueDepth];
  logic [PtrWidth-1:0]   wr_ptr, rd_ptr;
  logic [PtrWidth:0]     fill, fill_next;
  logic [PtrWidth-1:0]   push_num, pop_num;
  result_t               head;

  assign item = '{content_byte: ingress.content_byte,
                  content_length: ingress.content_length,
                  first_byte: ingress.first_byte,
                  final_byte: ingress.final_byte};

  assign ingress.ready = fill <= (PtrWidth + 1)'(QueueDepth - 2);
  assign in_acc = ingress.valid && ingress.ready;
  assign out_acc = egress.valid && egress.ready;

  oid_step #(.MAX_IDENTIFIERS(MAX_IDENTIFIERS)) u_step (
    .clk(clk),
    .rst(rst),
    .accept(in_acc),
    .item(item),
    .res0(res0),
    .res1(res1),
    .res_num(res_num)
  );

  assign push_num = in_acc ? PtrWidth'(res_num) : '0;
  assign pop_num = PtrWidth'(out_acc);
  assign fill_next = fill + (PtrWidth + 1)'(push_num) - (PtrWidth + 1)'(pop_num);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_num;
      rd_ptr <= rd_ptr + pop_num;
      fill <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && res_num != 2'd0) begin
      queue[wr_ptr] <= res0;
    end
    if (in_acc && res_num == 2'd2) begin
      queue[wr_ptr + PtrWidth'(1)] <= res1;
    end
  end

  assign head = queue[rd_ptr];
  assign egress.valid = fill != '0;
  assign egress.identifier_valid = head.identifier_valid;
  assign egress.identifier_value = head.identifier_value;
  assign egress.identifier_position = head.identifier_position;
  assign egress.end_of_object = head.end_of_object;
  assign egress.too_long = head.too_long;
  assign egress.identifier_count = head.identifier_count;

endmodule

// ----- sim/oid_decode_checker.sv -----
`timescale 1ns / 1ps

module oid_decode_checker
  import oid_pkg::*;
#(
  parameter int unsigned MAX_IDENTIFIERS = MaxIdentifiersDefault
) (
  input  logic clk,
  input  logic rst,
  oid_in_if    ingress,
  oid_out_if   egress,
  output int   fail_count,
  output int   expected_left
);

  result_t               expected_results[$];
  logic [ValueWidth-1:0] acc;
  logic [CountWidth-1:0] count;
  logic                  skipping;
  item_t                 word_in;
  result_t               seen;
  result_t               oldest;
  int                    mismatches = 0;

  assign fail_count = mismatches;

  function automatic result_t make_result(input logic valid, input logic [ValueWidth-1:0] value,
                                          input logic [PosWidth-1:0] pos, input logic eoo,
                                          input logic err, input logic [CountWidth-1:0] cnt);
    result_t r;
    r.identifier_valid    = valid;
    r.identifier_value    = value;
    r.identifier_position = pos;
    r.end_of_object       = eoo;
    r.too_long            = err;
    r.identifier_count    = cnt;
    return r;
  endfunction

  function automatic void decode_word(input item_t it);
    logic [ValueWidth-1:0] gathered;
    logic                  emit;
    logic [PosWidth-1:0]   pos;
    if (it.first_byte) begin
      acc      = '0;
      count    = '0;
      skipping = 1'b0;
      if (32'(it.content_length) > MAX_IDENTIFIERS - 1) begin
        skipping = 1'b1;
        expected_results.push_back(make_result(1'b0, '0, '0, 1'b1, 1'b1, '0));
      end else if (it.content_length == '0) begin
        skipping = 1'b1;
        count    = CountWidth'(2);
        expected_results.push_back(make_result(1'b1, '0, '0, 1'b0, 1'b0, '0));
        expected_results.push_back(make_result(1'b1, '0, PosWidth'(1), 1'b1, 1'b0,
                                               CountWidth'(2)));
      end else begin
        count = CountWidth'(2);
        expected_results.push_back(make_result(1'b1, ValueWidth'(it.content_byte / FirstArcDivisor),
                                               '0, 1'b0, 1'b0, '0));
        expected_results.push_back(make_result(1'b1, ValueWidth'(it.content_byte % FirstArcDivisor),
                                               PosWidth'(1), it.final_byte, 1'b0,
                                               it.final_byte ? CountWidth'(2) : '0));
        if (it.final_byte) skipping = 1'b1;
      end
    end else if (!skipping) begin
      gathered = (acc << 7) + ValueWidth'(it.content_byte & GroupMask);
      emit     = 1'b0;
      pos      = '0;
      acc      = gathered;
      if ((it.content_byte & MoreMask) == '0) begin
        if (32'(count) < MAX_IDENTIFIERS) begin
          emit  = 1'b1;
          pos   = count[PosWidth-1:0];
          count = count + 1'b1;
        end
        acc = '0;
      end
      if (it.final_byte) begin
        skipping = 1'b1;
        acc      = '0;
        expected_results.push_back(make_result(emit, emit ? gathered : '0, pos, 1'b1, 1'b0,
                                               count));
      end else if (emit) begin
        expected_results.push_back(make_result(1'b1, gathered, pos, 1'b0, 1'b0, '0));
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      acc      = '0;
      count    = '0;
      skipping = 1'b0;
      expected_results.delete();
    end else begin
      if (ingress.valid && ingress.ready) begin
        word_in.content_byte   = ingress.content_byte;
        word_in.content_length = ingress.content_length;
        word_in.first_byte     = ingress.first_byte;
        word_in.final_byte     = ingress.final_byte;
        decode_word(word_in);
      end
      if (egress.valid && egress.ready) begin
        seen.identifier_valid    = egress.identifier_valid;
        seen.identifier_value    = egress.identifier_value;
        seen.identifier_position = egress.identifier_position;
        seen.end_of_object       = egress.end_of_object;
        seen.too_long            = egress.too_long;
        seen.identifier_count    = egress.identifier_count;
        if (expected_results.size() == 0) begin
          report_mismatch("word with nothing pending, value", seen.identifier_value, 0);
        end else begin
          oldest = expected_results.pop_front();
          if (seen.identifier_valid !== oldest.identifier_valid)
            report_mismatch("identifier_valid", seen.identifier_valid, oldest.identifier_valid);
          if (seen.identifier_value !== oldest.identifier_value)
            report_mismatch("identifier_value", seen.identifier_value, oldest.identifier_value);
          if (seen.identifier_position !== oldest.identifier_position)
            report_mismatch("identifier_position", seen.identifier_position,
                            oldest.identifier_position);
          if (seen.end_of_object !== oldest.end_of_object)
            report_mismatch("end_of_object", seen.end_of_object, oldest.end_of_object);
          if (seen.too_long !== oldest.too_long)
            report_mismatch("too_long", seen.too_long, oldest.too_long);
          if (seen.identifier_count !== oldest.identifier_count)
            report_mismatch("identifier_count", seen.identifier_count, oldest.identifier_count);
        end
      end
    end
    expected_left <= expected_results.size();
  end

endmodule

// ----- sim/object_identifier_decoder_core_tb.sv -----
`timescale 1ns / 1ps

module object_identifier_decoder_core_tb;
  import oid_pkg::*;

  localparam int unsigned MaxIds     = MaxIdentifiersDefault;
  localparam int          CycleLimit = 200000;
  localparam int          LiveTarget = 550;
  localparam int          QuietFrom  = 470;
  localparam int          LongStall  = 300;

  logic clk;
  logic rst;
  int   fail_count;
  int   expected_left;
  int   live_items = 0;
  int   cycles = 0;
  int   pick;
  bit   quiet = 1'b0;
  bit   long_stall_due = 1'b0;

  oid_in_if  ingress ();
  oid_out_if egress ();

  object_identifier_decoder_core #(.MAX_IDENTIFIERS(MaxIds)) DUT (
    .clk     (clk),
    .rst     (rst),
    .ingress (ingress),
    .egress  (egress)
  );

  oid_decode_checker #(.MAX_IDENTIFIERS(MaxIds)) decode_check (
    .clk           (clk),
    .rst           (rst),
    .ingress       (ingress),
    .egress        (egress),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_word(input logic [7:0] b, input logic [LenWidth-1:0] len,
                           input logic first, input logic last, input bit live);
    ingress.valid          <= 1'b1;
    ingress.content_byte   <= b;
    ingress.content_length <= len;
    ingress.first_byte     <= first;
    ingress.final_byte     <= last;
    @(posedge clk);
    while (!ingress.ready) @(posedge clk);
    if (live) live_items++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      ingress.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // well-formed identifier: first byte, n values of random group count, optional dangling groups
  task automatic send_oid(input int n_values, input int max_groups, input bit trailing);
    logic [7:0]          oid_bytes[$];
    logic [LenWidth-1:0] len;
    int                  groups;
    oid_bytes.push_back(8'($urandom_range(0, 255)));
    for (int v = 0; v < n_values; v++) begin
      groups = $urandom_range(1, max_groups);
      for (int g = 1; g < groups; g++) oid_bytes.push_back(MoreMask | 8'($urandom_range(0, 127)));
      oid_bytes.push_back(8'($urandom_range(0, 127)));
    end
    if (trailing)
      repeat ($urandom_range(1, 2)) oid_bytes.push_back(MoreMask | 8'($urandom_range(0, 127)));
    if (oid_bytes.size() <= MaxIds - 1 && $urandom_range(0, 7) != 0)
      len = LenWidth'(oid_bytes.size());
    else
      len = LenWidth'($urandom_range(1, MaxIds - 1));
    foreach (oid_bytes[i])
      send_word(oid_bytes[i], len, i == 0, i == oid_bytes.size() - 1, 1'b1);
  endtask

  // first word that ends the object at once (over-long or empty), then up to three ignored words
  task automatic send_discarded(input logic [LenWidth-1:0] len);
    int tail;
    tail = $urandom_range(0, 3);
    send_word(8'($urandom_range(0, 255)), len, 1'b1, tail == 0 ? 1'($urandom_range(0, 1)) : 1'b0,
              1'b1);
    for (int i = 1; i <= tail; i++)
      send_word(8'($urandom_range(0, 255)), len, 1'b0, i == tail, 1'b0);
  endtask

  initial begin
    rst                    <= 1'b1;
    ingress.valid          <= 1'b0;
    ingress.content_byte   <= '0;
    ingress.content_length <= '0;
    ingress.first_byte     <= 1'b0;
    ingress.final_byte     <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // continuation words straight out of reset
    send_word(8'h81, 16'd3, 1'b0, 1'b0, 1'b1);
    send_word(8'h01, 16'd3, 1'b0, 1'b0, 1'b1);
    send_word(8'h85, 16'd3, 1'b0, 1'b1, 1'b1);
    // empty object, then ignored words
    send_word(8'hA5, 16'd0, 1'b1, 1'b0, 1'b1);
    send_word(8'h01, 16'd0, 1'b0, 1'b0, 1'b0);
    send_word(8'h02, 16'd0, 1'b0, 1'b1, 1'b0);
    // over-long lengths
    send_word(8'h2B, 16'(MaxIds), 1'b1, 1'b0, 1'b1);
    send_word(8'h05, 16'(MaxIds), 1'b0, 1'b1, 1'b0);
    send_word(8'hFF, 16'hFFFF, 1'b1, 1'b1, 1'b1);
    // single-word objects
    send_word(8'h00, 16'd1, 1'b1, 1'b1, 1'b1);
    send_word(8'hFF, 16'd1, 1'b1, 1'b1, 1'b1);
    // longest legal length, wrapping value, zero value, dangling last group
    send_word(8'h2B, 16'(MaxIds - 1), 1'b1, 1'b0, 1'b1);
    repeat (5) send_word(8'hFF, 16'(MaxIds - 1), 1'b0, 1'b0, 1'b1);
    send_word(8'h7F, 16'(MaxIds - 1), 1'b0, 1'b0, 1'b1);
    send_word(8'h00, 16'(MaxIds - 1), 1'b0, 1'b0, 1'b1);
    send_word(8'h80, 16'(MaxIds - 1), 1'b0, 1'b0, 1'b1);
    send_word(8'h7F, 16'(MaxIds - 1), 1'b0, 1'b0, 1'b1);
    send_word(8'h86, 16'(MaxIds - 1), 1'b0, 1'b1, 1'b1);
    send_word(8'h01, 16'(MaxIds - 1), 1'b0, 1'b0, 1'b0);
    // object closed by a complete value
    send_word(8'd80, 16'd2, 1'b1, 1'b0, 1'b1);
    send_word(8'h7F, 16'd2, 1'b0, 1'b1, 1'b1);

    long_stall_due = 1'b1;
    // count filled exactly, then overrun
    send_oid(MaxIds - 2, 1, 1'b0);
    send_oid(MaxIds + 5, 1, 1'b0);

    while (live_items < LiveTarget) begin
      quiet = (live_items >= QuietFrom);
      pick  = $urandom_range(0, 99);
      if (pick < 66)
        send_oid($urandom_range(0, 6), 5, $urandom_range(0, 5) == 0);
      else if (pick < 76)
        send_discarded(LenWidth'($urandom_range(MaxIds, 65535)));
      else if (pick < 84)
        send_discarded('0);
      else
        repeat ($urandom_range(1, 4))
          send_word(8'($urandom_range(0, 255)),
                    $urandom_range(0, 1) ? LenWidth'($urandom_range(0, 65535))
                                         : LenWidth'($urandom_range(0, MaxIds - 1)),
                    $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0, 1'b1);
    end
    quiet = 1'b1;
    ingress.valid <= 1'b0;

    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    egress.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      egress.ready <= 1'b1;
      @(posedge clk);
      if (long_stall_due) begin
        long_stall_due = 1'b0;
        egress.ready <= 1'b0;
        repeat (LongStall) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        egress.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
    end
  end

  initial begin
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule
